// ===== src/s2lab_pkg.sv =====
// s2lab_pkg: constants, lookup table and helper functions for the sRGB to CIELAB pixel core.
// Holds the gamma table (built at elaboration), matrix and white-point constants,
// and the cube-root step functions. No dependencies.
package s2lab_pkg;

	localparam int FRAC_BITS_DEF = 4;

	localparam int LIN_W      = 31;
	localparam int COEF_W     = 24;
	localparam int XP_W       = 55;
	localparam int NUM_W      = 55;
	localparam int T_W        = 31;
	localparam int TL_W       = 24;
	localparam int REM_W      = 26;
	localparam int NL_W       = 39;
	localparam int FL_W       = 29;
	localparam int FREM_W     = 13;
	localparam int FLM_W      = 40;
	localparam int R_W        = 31;
	localparam int R2_W       = 62;
	localparam int PROD_W     = 63;
	localparam int OM_W       = 42;
	localparam int ROOT_STEPS = 31;

	localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF = 64'd1 << 29;

	localparam logic [COEF_W-1:0] MAT_COEF [3][3] = '{
		'{24'd4124564, 24'd3575761, 24'd1804375},
		'{24'd2126729, 24'd7151522, 24'd721750},
		'{24'd193339,  24'd1191920, 24'd9503041}
	};

	localparam logic [COEF_W-1:0] XYZ_W10   [3] = '{24'd9504560, 24'd10000000, 24'd10887540};
	localparam logic [COEF_W-1:0] XYZ_WHALF [3] = '{24'd4752280, 24'd5000000, 24'd5443770};
	localparam logic [31:0] XYZ_RECIP [3] = '{
		32'((64'd1 << 55) / 64'd9504560),
		32'((64'd1 << 55) / 64'd10000000),
		32'((64'd1 << 55) / 64'd10887540)
	};

	// f(t) linear segment: (9033 t + 160 * 2^30 + 580) / 1160
	localparam logic [T_W-1:0]  T_LIN    = T_W'((64'd8856 << 30) / 64'd1000000);
	localparam logic [13:0]     FL_MUL   = 14'd9033;
	localparam logic [NL_W-1:0] FL_OFS   = NL_W'((64'd160 << 30) + 64'd580);
	localparam logic [10:0]     FL_DIV   = 11'd1160;
	localparam logic [31:0]     FL_RECIP = 32'((64'd1 << 42) / 64'd1160);

	typedef logic [LIN_W-1:0] lin_tab_t [256];

	typedef struct packed {
		logic [T_W-1:0]  t;
		logic [FL_W-1:0] fl;
		logic            big;
		logic [R_W-1:0]  r;
		logic [R2_W-1:0] r2;
		logic [R_W-1:0]  cand;
		logic [R2_W-1:0] c2;
	} root_lane_t;

	function automatic logic [63:0] pow_q30(logic [63:0] r, int n);
		logic [63:0] p;
		p = r;
		for (int k = 1; k < n; k++) begin
			p = (p * r) >> 30;
		end
		return p;
	endfunction

	function automatic logic [63:0] root_q30(logic [63:0] target, int n, logic [63:0] hi_excl);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd0;
		hi = hi_excl;
		while (hi - lo > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			if (pow_q30(mid, n) <= target) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic logic [LIN_W-1:0] lin_value(logic [63:0] c);
		logic [63:0] v;
		logic [63:0] v2;
		logic [63:0] r;
		if (c * 64'd100000 <= 64'd1031475) begin
			return LIN_W'((c * 64'd100 * Q30_ONE + 64'd164730) / 64'd329460);
		end
		v  = ((64'd1000 * c + 64'd14025) * Q30_ONE + 64'd134512) / 64'd269025;
		v2 = (v * v + Q30_HALF) >> 30;
		r  = root_q30(v2, 5, Q30_ONE + 64'd1);
		return LIN_W'((v2 * r + Q30_HALF) >> 30);
	endfunction

	function automatic lin_tab_t build_lin_tab();
		lin_tab_t tab;
		for (int c = 0; c < 256; c++) begin
			tab[c] = lin_value(64'(c));
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

	// one bit of the cube-root search: settle the previous trial, set up the next
	function automatic root_lane_t root_advance(root_lane_t prev, logic [PROD_W-1:0] prod,
			int bitpos);
		root_lane_t nxt;
		logic       ok;
		ok  = prod[PROD_W-1:30] <= {2'b00, prev.t};
		nxt = prev;
		if (ok) begin
			nxt.r  = prev.cand;
			nxt.r2 = prev.c2;
		end
		nxt.cand = nxt.r | (R_W'(1) << bitpos);
		nxt.c2   = nxt.r2 + (R2_W'(nxt.r) << (bitpos + 1)) + (R2_W'(1) << (2 * bitpos));
		return nxt;
	endfunction

	function automatic logic [T_W-1:0] root_final(root_lane_t prev, logic [PROD_W-1:0] prod);
		logic           ok;
		logic [R_W-1:0] r;
		ok = prod[PROD_W-1:30] <= {2'b00, prev.t};
		r  = ok ? prev.cand : prev.r;
		return prev.big ? T_W'(r) : T_W'(prev.fl);
	endfunction

endpackage

// ===== src/srgb_to_cielab_pixel_core.sv =====
// Throughput: one pixel per cycle while not stalled; the cube-root search (31 bits, two stages per bit:
// square update, then cube multiply) sets the depth.
// Output stall freezes the whole pipeline once the beat in flight lands in a one-entry skid
// register. Reset (arst_n, async, active low) clears valid bits only.
// srgb_to_cielab_pixel_core: sRGB to CIELAB (D65) converter. Uses s2lab_pkg.
module srgb_to_cielab_pixel_core
	import s2lab_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               lab_valid,
	input  logic               lab_stall,
	output logic [10:0]        lightness,
	output logic signed [11:0] a_star,
	output logic signed [11:0] b_star
);

	localparam int LMAX_RAW = 100 << FRAC_BITS;
	localparam int LMAX     = (LMAX_RAW > 2047) ? 2047 : LMAX_RAW;
	localparam int SH_W     = OM_W + 1 + FRAC_BITS;
	localparam int RES_W    = SH_W - 30;

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	logic [ROOT_STEPS-1:0] vld_sa, vld_sb;

	logic [LIN_W-1:0]  lin_s1   [3];
	logic [XP_W-1:0]   prod_s2  [3][3];
	logic [NUM_W-1:0]  num_s3   [3];
	logic [T_W-1:0]    qe_s4    [3];
	logic [REM_W-1:0]  numlo_s4 [3];
	logic [T_W-1:0]    qe_s5    [3];
	logic [REM_W-1:0]  numlo_s5 [3];
	logic [REM_W-1:0]  qw_s5    [3];
	logic [T_W-1:0]    qe_s6    [3];
	logic [REM_W-1:0]  rem_s6   [3];
	logic [T_W-1:0]    t_s7     [3];
	logic [T_W-1:0]    t_s8     [3];
	logic              big_s8   [3];
	logic [NL_W-1:0]   nl_s8    [3];
	logic [T_W-1:0]    t_s9     [3];
	logic              big_s9   [3];
	logic [FL_W-1:0]   ql_s9    [3];
	logic [FREM_W-1:0] nllo_s9  [3];
	logic [T_W-1:0]    t_s10    [3];
	logic              big_s10  [3];
	logic [FL_W-1:0]   ql_s10   [3];
	logic [FREM_W-1:0] nllo_s10 [3];
	logic [FREM_W-1:0] qlw_s10  [3];
	logic [T_W-1:0]    t_s11    [3];
	logic              big_s11  [3];
	logic [FL_W-1:0]   ql_s11   [3];
	logic [FREM_W-1:0] reml_s11 [3];
	logic [T_W-1:0]    t_s12    [3];
	logic              big_s12  [3];
	logic [FL_W-1:0]   fl_s12   [3];

	root_lane_t        root_sa [ROOT_STEPS][3];
	root_lane_t        root_sb [ROOT_STEPS][3];
	logic [PROD_W-1:0] prod_sb [ROOT_STEPS][3];

	logic [T_W-1:0]    f_s13   [3];
	logic [OM_W-1:0]   m_s14   [3];
	logic [OM_W-1:0]   mag_s15 [3];
	logic              neg_s15 [3];

	logic [63:0]       qe_full  [3];
	logic [XP_W-1:0]   qw_full  [3];
	logic [63:0]       ql_full  [3];
	logic [FLM_W-1:0]  qlw_full [3];
	root_lane_t        seed     [3];
	root_lane_t        nxt_sa   [ROOT_STEPS][3];
	logic [PROD_W-1:0] mul_sb   [ROOT_STEPS][3];

	logic [SH_W-1:0]   sh  [3];
	logic [RES_W-1:0]  res [3];
	logic [RES_W-1:0]  lim [3];
	logic [11:0]       sat [3];
	logic [10:0]       o3_l;
	logic [11:0]       o3_a, o3_b;

	logic              out_vld_q, skid_vld_q;
	logic [10:0]       l_q, sk_l_q;
	logic signed [11:0] a_q, b_q, sk_a_q, sk_b_q;

	assign en        = !skid_vld_q;
	assign pix_stall = skid_vld_q;
	assign lab_valid = out_vld_q;
	assign lightness = l_q;
	assign a_star    = a_q;
	assign b_star    = b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_sa  <= '0;
			vld_sb  <= '0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else if (en) begin
			vld_s1  <= pix_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_sa  <= {vld_sb[ROOT_STEPS-2:0], vld_s12};
			vld_sb  <= vld_sa;
			vld_s13 <= vld_sb[ROOT_STEPS-1];
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
		end
	end

	// XYZ divide by reciprocal, linear f(t) divide, cube-root trial setup and cube multiply
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe_full[i]  = 64'(num_s3[i][NUM_W-1:23]) * 64'(XYZ_RECIP[i]);
			qw_full[i]  = XP_W'(qe_s4[i]) * XP_W'(XYZ_W10[i]);
			ql_full[i]  = 64'(nl_s8[i][NL_W-1:10]) * 64'(FL_RECIP);
			qlw_full[i] = FLM_W'(ql_s9[i]) * FLM_W'(FL_DIV);
			seed[i]     = '{t: t_s12[i], fl: fl_s12[i], big: big_s12[i],
				r: '0, r2: '0, cand: '0, c2: '0};
			nxt_sa[0][i] = root_advance(seed[i], '1, ROOT_STEPS - 1);
		end
		for (int k = 1; k < ROOT_STEPS; k++) begin
			for (int i = 0; i < 3; i++) begin
				nxt_sa[k][i] = root_advance(root_sb[k-1][i], prod_sb[k-1][i],
					ROOT_STEPS - 1 - k);
			end
		end
		for (int k = 0; k < ROOT_STEPS; k++) begin
			for (int i = 0; i < 3; i++) begin
				mul_sb[k][i] = PROD_W'(root_sa[k][i].c2[R2_W-1:30]) *
					PROD_W'(root_sa[k][i].cand);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= LIN_TAB[red];
			lin_s1[1] <= LIN_TAB[green];
			lin_s1[2] <= LIN_TAB[blue];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= XP_W'(lin_s1[j]) * XP_W'(MAT_COEF[i][j]);
				end
				num_s3[i] <= prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2] +
					NUM_W'(XYZ_WHALF[i]);

				qe_s4[i]    <= qe_full[i][62:32];
				numlo_s4[i] <= num_s3[i][REM_W-1:0];

				qe_s5[i]    <= qe_s4[i];
				numlo_s5[i] <= numlo_s4[i];
				qw_s5[i]    <= qw_full[i][REM_W-1:0];

				qe_s6[i]  <= qe_s5[i];
				rem_s6[i] <= numlo_s5[i] - qw_s5[i];

				t_s7[i] <= qe_s6[i]
					+ T_W'(rem_s6[i] >= REM_W'(XYZ_W10[i]))
					+ T_W'(rem_s6[i] >= (REM_W'(XYZ_W10[i]) << 1))
					+ T_W'(rem_s6[i] >= REM_W'(XYZ_W10[i]) * REM_W'(3));

				t_s8[i]   <= t_s7[i];
				big_s8[i] <= t_s7[i] > T_LIN;
				nl_s8[i]  <= NL_W'(FL_MUL) * NL_W'(t_s7[i][TL_W-1:0]) + FL_OFS;

				t_s9[i]    <= t_s8[i];
				big_s9[i]  <= big_s8[i];
				ql_s9[i]   <= ql_full[i][60:32];
				nllo_s9[i] <= nl_s8[i][FREM_W-1:0];

				t_s10[i]    <= t_s9[i];
				big_s10[i]  <= big_s9[i];
				ql_s10[i]   <= ql_s9[i];
				nllo_s10[i] <= nllo_s9[i];
				qlw_s10[i]  <= qlw_full[i][FREM_W-1:0];

				t_s11[i]    <= t_s10[i];
				big_s11[i]  <= big_s10[i];
				ql_s11[i]   <= ql_s10[i];
				reml_s11[i] <= nllo_s10[i] - qlw_s10[i];

				t_s12[i]   <= t_s11[i];
				big_s12[i] <= big_s11[i];
				fl_s12[i]  <= ql_s11[i]
					+ FL_W'(reml_s11[i] >= FREM_W'(FL_DIV))
					+ FL_W'(reml_s11[i] >= (FREM_W'(FL_DIV) << 1))
					+ FL_W'(reml_s11[i] >= FREM_W'(FL_DIV) * FREM_W'(3));
			end
			for (int k = 0; k < ROOT_STEPS; k++) begin
				for (int i = 0; i < 3; i++) begin
					root_sa[k][i] <= nxt_sa[k][i];
					root_sb[k][i] <= root_sa[k][i];
					prod_sb[k][i] <= mul_sb[k][i];
				end
			end
			for (int i = 0; i < 3; i++) begin
				f_s13[i] <= root_final(root_sb[ROOT_STEPS-1][i], prod_sb[ROOT_STEPS-1][i]);
			end
			m_s14[0] <= OM_W'(116) * OM_W'(f_s13[1]) - OM_W'(Q30_ONE << 4);
			m_s14[1] <= OM_W'(500) * (OM_W'(f_s13[0]) - OM_W'(f_s13[1]));
			m_s14[2] <= OM_W'(200) * (OM_W'(f_s13[1]) - OM_W'(f_s13[2]));
			for (int i = 0; i < 3; i++) begin
				neg_s15[i] <= m_s14[i][OM_W-1];
				mag_s15[i] <= m_s14[i][OM_W-1] ? (~m_s14[i] + OM_W'(1)) : m_s14[i];
			end
		end
	end

	// round half away from zero, then saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]  = (SH_W'(mag_s15[i]) << FRAC_BITS) + SH_W'(Q30_HALF);
			res[i] = sh[i][SH_W-1:30];
			lim[i] = neg_s15[i] ? RES_W'(2048) : RES_W'(2047);
			sat[i] = (res[i] > lim[i]) ? lim[i][11:0] : res[i][11:0];
		end
		if (neg_s15[0]) begin
			o3_l = 11'd0;
		end else if (res[0] > RES_W'(LMAX)) begin
			o3_l = 11'(LMAX);
		end else begin
			o3_l = res[0][10:0];
		end
		o3_a = neg_s15[1] ? (~sat[1] + 12'd1) : sat[1];
		o3_b = neg_s15[2] ? (~sat[2] + 12'd1) : sat[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !lab_stall) begin
			out_vld_q  <= skid_vld_q | vld_s15;
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			skid_vld_q <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !lab_stall) begin
			if (skid_vld_q) begin
				l_q <= sk_l_q;
				a_q <= sk_a_q;
				b_q <= sk_b_q;
			end else begin
				l_q <= o3_l;
				a_q <= $signed(o3_a);
				b_q <= $signed(o3_b);
			end
		end else if (!skid_vld_q) begin
			sk_l_q <= o3_l;
			sk_a_q <= $signed(o3_a);
			sk_b_q <= $signed(o3_b);
		end
	end

	ast_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	ast_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && lab_stall))
		else $error("skid filled without an output stall");

	ast_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_s15))
		else $error("pipeline moved while skid was full");

	ast_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (l_q <= 11'(LMAX)))
		else $error("lightness above its bound");

endmodule
